// ----- design/rmq_pkg.sv -----
package rmq_pkg;

   localparam int WORD_BITS = 16;
   localparam int FRAC      = WORD_BITS - 2;
   localparam int NUM_W     = WORD_BITS + 1;
   localparam int RAD_W     = WORD_BITS + 1;
   localparam int SQX_W     = 2 * WORD_BITS;
   localparam int ROOT_W    = WORD_BITS;
   localparam int SREM_W    = ROOT_W + 2;
   localparam int DVD_W     = NUM_W + FRAC;
   localparam int DVS_W     = ROOT_W + 1;
   localparam int QUO_W     = DVD_W;
   localparam int LANES     = 4;

   localparam logic [1:0] SLOT_REAL = 2'd0;
   localparam logic [1:0] SLOT_X    = 2'd1;
   localparam logic [1:0] SLOT_Y    = 2'd2;
   localparam logic [1:0] SLOT_Z    = 2'd3;

   localparam logic [WORD_BITS-1:0] ONE_Q  = {2'b01, {FRAC{1'b0}}};
   localparam logic [WORD_BITS-1:0] SMAX_Q = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] SMIN_Q = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef logic signed [NUM_W-1:0] num_type;

   typedef struct packed {
      num_type [LANES-1:0] num;
      logic [1:0]          axis;
   } side_type;

endpackage

// ----- design/rmq_front.sv -----
module rmq_front
   import rmq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [WORD_BITS-1:0] m11,
   input  logic signed [WORD_BITS-1:0] m12,
   input  logic signed [WORD_BITS-1:0] m13,
   input  logic signed [WORD_BITS-1:0] m21,
   input  logic signed [WORD_BITS-1:0] m22,
   input  logic signed [WORD_BITS-1:0] m23,
   input  logic signed [WORD_BITS-1:0] m31,
   input  logic signed [WORD_BITS-1:0] m32,
   input  logic signed [WORD_BITS-1:0] m33,
   output logic                        out_valid,
   output logic [SQX_W-1:0]            out_x,
   output side_type                    out_side
);

   logic                    valid_ff;
   logic [SQX_W-1:0]        x_ff;
   side_type                side_ff;
   logic [SQX_W-1:0]        x_in;
   side_type                side_in;
   logic signed [RAD_W:0]   rad;
   logic signed [RAD_W:0]   d11, d22, d33, one_w;

   function automatic num_type nsum(input logic signed [WORD_BITS-1:0] a,
                                    input logic signed [WORD_BITS-1:0] b,
                                    input logic sub);
      num_type ea, eb;
      ea = {a[WORD_BITS-1], a};
      eb = {b[WORD_BITS-1], b};
      return sub ? ea - eb : ea + eb;
   endfunction

   always_comb begin
      d11   = {{2{m11[WORD_BITS-1]}}, m11};
      d22   = {{2{m22[WORD_BITS-1]}}, m22};
      d33   = {{2{m33[WORD_BITS-1]}}, m33};
      one_w = {2'b00, ONE_Q};
      side_in.num[SLOT_X] = nsum(m12, m21, 1'b0);
      side_in.num[SLOT_Y] = nsum(m12, m21, 1'b0);
      side_in.num[SLOT_Z] = nsum(m31, m13, 1'b0);
      priority if (m11 > m22 && m11 > m33) begin
         side_in.axis           = SLOT_X;
         rad                    = one_w + d11 - d22 - d33;
         side_in.num[SLOT_REAL] = nsum(m32, m23, 1'b1);
      end else if (m22 > m11 && m22 > m33) begin
         side_in.axis           = SLOT_Y;
         rad                    = one_w + d22 - d33 - d11;
         side_in.num[SLOT_REAL] = nsum(m13, m31, 1'b1);
         side_in.num[SLOT_Z]    = nsum(m23, m32, 1'b0);
      end else begin
         side_in.axis           = SLOT_Z;
         rad                    = one_w + d33 - d11 - d22;
         side_in.num[SLOT_REAL] = nsum(m21, m12, 1'b1);
         side_in.num[SLOT_X]    = nsum(m31, m13, 1'b0);
         side_in.num[SLOT_Y]    = nsum(m23, m32, 1'b0);
      end
      if (rad[RAD_W]) begin
         x_in = '0;
      end else begin
         x_in = {1'b0, rad[RAD_W-1:0], {FRAC{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         x_ff    <= x_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_side  = side_ff;

endmodule

// ----- design/rmq_sqrt.sv -----
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SQX_W-1:0]  in_x,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic              v_ff    [ROOT_W];
   logic [SQX_W-1:0]  x_ff    [ROOT_W];
   logic [SREM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   side_type          side_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic              pv;
      logic [SQX_W-1:0]  px;
      logic [SREM_W-1:0] prem, t, trial;
      logic [ROOT_W-1:0] proot;
      side_type          pside;
      logic              ge;

      if (g == 0) begin : g_first
         assign pv    = in_valid;
         assign px    = in_x;
         assign prem  = '0;
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[g-1];
         assign px    = x_ff[g-1];
         assign prem  = rem_ff[g-1];
         assign proot = root_ff[g-1];
         assign pside = side_ff[g-1];
      end

      assign t     = {prem[SREM_W-3:0], px[SQX_W-1 -: 2]};
      assign trial = {proot, 2'b01};
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= pv;
         end
         if (en) begin
            x_ff[g]    <= {px[SQX_W-3:0], 2'b00};
            rem_ff[g]  <= ge ? t - trial : t;
            root_ff[g] <= {proot[ROOT_W-2:0], ge};
            side_ff[g] <= pside;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ----- design/rmq_div.sv -----
module rmq_div
   import rmq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [ROOT_W-1:0]            in_root,
   input  side_type                     in_side,
   output logic                         out_valid,
   output logic [DVS_W-1:0]             out_dvs,
   output logic [1:0]                   out_axis,
   output logic [LANES-1:0]             out_neg,
   output logic [LANES-1:0][QUO_W-1:0]  out_quo
);

   logic                         v_ff    [QUO_W];
   logic [DVS_W-1:0]             dvs_ff  [QUO_W];
   logic [1:0]                   axis_ff [QUO_W];
   logic [LANES-1:0]             neg_ff  [QUO_W];
   logic [LANES-1:0][DVS_W-1:0]  rem_ff  [QUO_W];
   logic [LANES-1:0][DVD_W-1:0]  dq_ff   [QUO_W];

   logic [LANES-1:0]             neg0;
   logic [LANES-1:0][DVD_W-1:0]  dq0;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg0[l] = in_side.num[l][NUM_W-1];
         dq0[l]  = {(neg0[l] ? -in_side.num[l] : in_side.num[l]), {FRAC{1'b0}}};
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_stage
      logic                         pv;
      logic [DVS_W-1:0]             pdvs;
      logic [1:0]                   paxis;
      logic [LANES-1:0]             pneg;
      logic [LANES-1:0][DVS_W-1:0]  prem, rem_in;
      logic [LANES-1:0][DVD_W-1:0]  pdq, dq_in;
      logic [DVS_W:0]               t;

      if (g == 0) begin : g_first
         assign pv    = in_valid;
         assign pdvs  = {in_root, 1'b0};
         assign paxis = in_side.axis;
         assign pneg  = neg0;
         assign prem  = '0;
         assign pdq   = dq0;
      end else begin : g_next
         assign pv    = v_ff[g-1];
         assign pdvs  = dvs_ff[g-1];
         assign paxis = axis_ff[g-1];
         assign pneg  = neg_ff[g-1];
         assign prem  = rem_ff[g-1];
         assign pdq   = dq_ff[g-1];
      end

      always_comb begin
         t = '0;
         for (int l = 0; l < LANES; l++) begin
            t = {prem[l], pdq[l][DVD_W-1]};
            if (t >= {1'b0, pdvs}) begin
               rem_in[l] = DVS_W'(t - {1'b0, pdvs});
               dq_in[l]  = {pdq[l][DVD_W-2:0], 1'b1};
            end else begin
               rem_in[l] = t[DVS_W-1:0];
               dq_in[l]  = {pdq[l][DVD_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= pv;
         end
         if (en) begin
            dvs_ff[g]  <= pdvs;
            axis_ff[g] <= paxis;
            neg_ff[g]  <= pneg;
            rem_ff[g]  <= rem_in;
            dq_ff[g]   <= dq_in;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_dvs   = dvs_ff[QUO_W-1];
   assign out_axis  = axis_ff[QUO_W-1];
   assign out_neg   = neg_ff[QUO_W-1];
   assign out_quo   = dq_ff[QUO_W-1];

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_m11 .. req_m33 (signed Q1.14)
// rsp_      out        rsp_valid / rsp_ready  rsp_q_real, rsp_q_x, rsp_q_y, rsp_q_z,
//                                             rsp_degenerate
//
// One matrix per cycle while the output is not stalled (the output register is empty or taken).
// The pipe runs from the front register through the bit-per-stage square root (16 stages)
// and the bit-per-stage divider (31 stages, four lanes in parallel) to the output register.
// The whole pipe advances together whenever the output register is empty or taken.
// Synchronous reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [WORD_BITS-1:0] req_m11,
   input  logic signed [WORD_BITS-1:0] req_m12,
   input  logic signed [WORD_BITS-1:0] req_m13,
   input  logic signed [WORD_BITS-1:0] req_m21,
   input  logic signed [WORD_BITS-1:0] req_m22,
   input  logic signed [WORD_BITS-1:0] req_m23,
   input  logic signed [WORD_BITS-1:0] req_m31,
   input  logic signed [WORD_BITS-1:0] req_m32,
   input  logic signed [WORD_BITS-1:0] req_m33,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_q_real,
   output logic signed [WORD_BITS-1:0] rsp_q_x,
   output logic signed [WORD_BITS-1:0] rsp_q_y,
   output logic signed [WORD_BITS-1:0] rsp_q_z,
   output logic                        rsp_degenerate
);

   logic                         en;
   logic                         f_valid, s_valid, d_valid;
   logic [SQX_W-1:0]             f_x;
   side_type                     f_side, s_side;
   logic [ROOT_W-1:0]            s_root;
   logic [DVS_W-1:0]             d_dvs;
   logic [1:0]                   d_axis;
   logic [LANES-1:0]             d_neg;
   logic [LANES-1:0][QUO_W-1:0]  d_quo;

   logic                               valid_ff;
   logic [LANES-1:0][WORD_BITS-1:0]    q_ff, q_in;
   logic                               degen_ff, degen_in;
   logic [WORD_BITS-1:0]               half;

   function automatic logic [WORD_BITS-1:0] sat_q(input logic neg,
                                                  input logic [QUO_W-1:0] quo);
      logic [QUO_W-1:0] lim_p, lim_n;
      lim_p = {{(QUO_W-WORD_BITS){1'b0}}, SMAX_Q};
      lim_n = {{(QUO_W-WORD_BITS){1'b0}}, SMIN_Q};
      if (neg) begin
         return (quo > lim_n) ? SMIN_Q : -quo[WORD_BITS-1:0];
      end
      return (quo > lim_p) ? SMAX_Q : quo[WORD_BITS-1:0];
   endfunction

   assign en        = !valid_ff || rsp_ready;
   assign req_ready = en;

   rmq_front u_front (
      .clock, .reset, .en,
      .in_valid (req_valid),
      .m11 (req_m11), .m12 (req_m12), .m13 (req_m13),
      .m21 (req_m21), .m22 (req_m22), .m23 (req_m23),
      .m31 (req_m31), .m32 (req_m32), .m33 (req_m33),
      .out_valid (f_valid),
      .out_x     (f_x),
      .out_side  (f_side)
   );

   rmq_sqrt u_sqrt (
      .clock, .reset, .en,
      .in_valid  (f_valid),
      .in_x      (f_x),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   rmq_div u_div (
      .clock, .reset, .en,
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_dvs   (d_dvs),
      .out_axis  (d_axis),
      .out_neg   (d_neg),
      .out_quo   (d_quo)
   );

   assign half = {1'b0, d_dvs[DVS_W-1:2]};

   always_comb begin
      degen_in = (d_dvs == '0);
      for (int l = 0; l < LANES; l++) begin
         if (degen_in) begin
            q_in[l] = (2'(l) == SLOT_REAL) ? ONE_Q : '0;
         end else if (2'(l) == d_axis) begin
            q_in[l] = half;
         end else begin
            q_in[l] = sat_q(d_neg[l], d_quo[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= d_valid;
      end
      if (en) begin
         q_ff     <= q_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_q_real     = q_ff[SLOT_REAL];
   assign rsp_q_x        = q_ff[SLOT_X];
   assign rsp_q_y        = q_ff[SLOT_Y];
   assign rsp_q_z        = q_ff[SLOT_Z];
   assign rsp_degenerate = degen_ff;

endmodule

// ----- design/rmq_checker.sv -----
module rmq_checker
   import rmq_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WORD_BITS-1:0] rsp_q_real,
   input logic signed [WORD_BITS-1:0] rsp_q_x,
   input logic signed [WORD_BITS-1:0] rsp_q_y,
   input logic signed [WORD_BITS-1:0] rsp_q_z,
   input logic                        rsp_degenerate
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_q_real == ONE_Q && rsp_q_x == '0 && rsp_q_y == '0 && rsp_q_z == '0)
      else $error("degenerate beat is not the identity");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_q_real, .rsp_q_x, .rsp_q_y, .rsp_q_z, .rsp_degenerate
);
